// ----- hw/rtl/brc_pkg.sv -----
package brc_pkg;

  // Coordinate and register widths
  localparam int CoordW = 10;
  localparam int CfgW   = 9;
  localparam int BoundW = CfgW + 1;
  localparam int DeltaW = CoordW;
  localparam int ErrW   = DeltaW + 1;

  // Default map size
  localparam int MapColumnsDef = 256;
  localparam int MapRowsDef    = 256;

  // Stream payload widths
  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  // Command queue between front and back
  localparam int CmdQueueDepth = 2;

  localparam logic [CfgW-1:0] WorldWidthRst  = CfgW'(256);
  localparam logic [CfgW-1:0] WorldHeightRst = CfgW'(256);

  typedef enum logic {
    ReqWrite = 1'b0,
    ReqCast  = 1'b1
  } req_e;

  typedef enum logic {
    RegWorldWidth  = 1'b0,
    RegWorldHeight = 1'b1
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DeltaW-1:0]        delta_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    req_e   kind;
    coord_t x;
    coord_t y;
    logic   solid;
    logic   step_x_neg;
    logic   step_y_neg;
    logic   x_major;
    delta_t major;
    delta_t minor;
  } cmd_t;

endpackage

// ----- hw/rtl/brc_ram.sv -----
module brc_ram #(
  parameter int Width = 1,
  parameter int Depth = 2,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/brc_fifo.sv -----
module brc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/brc_front.sv -----
module brc_front (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [brc_pkg::InDataW-1:0]  in_data_i,   // start_x, start_y, end_x, end_y, solid
  input  logic                         in_user_i,   // req_type
  input  logic                         clear_busy_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output brc_pkg::cmd_t                cmd_o
);

  import brc_pkg::*;

  coord_t sx, sy, ex, ey;
  logic signed [CoordW:0] dx, dy, neg_dx, neg_dy;
  delta_t adx, ady;

  assign sx = in_data_i[CoordW-1:0];
  assign sy = in_data_i[2*CoordW-1:CoordW];
  assign ex = in_data_i[3*CoordW-1:2*CoordW];
  assign ey = in_data_i[4*CoordW-1:3*CoordW];

  // Signed deltas, one bit wider than a coordinate
  assign dx     = {ex[CoordW-1], ex} - {sx[CoordW-1], sx};
  assign dy     = {ey[CoordW-1], ey} - {sy[CoordW-1], sy};
  assign neg_dx = -dx;
  assign neg_dy = -dy;
  assign adx    = dx[CoordW] ? neg_dx[DeltaW-1:0] : dx[DeltaW-1:0];
  assign ady    = dy[CoordW] ? neg_dy[DeltaW-1:0] : dy[DeltaW-1:0];

  always_comb begin
    cmd_o.kind       = req_e'(in_user_i);
    cmd_o.x          = sx;
    cmd_o.y          = sy;
    cmd_o.solid      = in_data_i[4*CoordW];
    cmd_o.step_x_neg = dx[CoordW];
    cmd_o.step_y_neg = dy[CoordW];
    cmd_o.x_major    = (adx >= ady);
    cmd_o.major      = (adx >= ady) ? adx : ady;
    cmd_o.minor      = (adx >= ady) ? ady : adx;
  end

  // Hold off new requests while the queue is full or the map is swept clear
  assign in_ready_o = !q_full_i && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

// ----- hw/rtl/brc_back.sv -----
module brc_back #(
  parameter int MapColumns = brc_pkg::MapColumnsDef,
  parameter int MapRows    = brc_pkg::MapRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [brc_pkg::CfgW-1:0]     col_limit_i,
  input  logic [brc_pkg::CfgW-1:0]     row_limit_i,
  input  brc_pkg::cmd_t                cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  output logic                         clear_busy_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [brc_pkg::OutDataW-1:0] res_data_o,  // before_x, before_y, impact_x, impact_y
  output logic                         res_user_o   // hit
);

  import brc_pkg::*;

  localparam int Depth = MapColumns * MapRows;
  localparam int AddrW = $clog2(Depth);
  localparam int XIdxW = $clog2(MapColumns);
  localparam int YIdxW = $clog2(MapRows);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StCast
  } state_e;

  state_e state_q;
  logic [AddrW-1:0] clr_addr_q;

  // Walker: issues one map read per cycle
  logic   walk_q;
  delta_t rem_q;
  logic [ErrW-1:0] err_q;
  coord_t cx_q, cy_q, px_q, py_q;
  logic   x_major_q, stx_neg_q, sty_neg_q;
  delta_t major_q, minor_q;

  // Check stage, aligned with the registered read data
  logic   s1_valid_q, s1_last_q, s1_inb_q;
  coord_t s1_x_q, s1_y_q, s1_px_q, s1_py_q;

  logic                out_valid_q, out_hit_q;
  logic [OutDataW-1:0] out_data_q;

  logic [BoundW-1:0] w_bound, h_bound;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [AddrW-1:0]  ram_addr;
  logic              cmd_pop, s1_hit;
  logic [ErrW-1:0]   err_sum, err_next;
  logic              err_wrap;
  coord_t            cx_next, cy_next;

  assign w_bound = ({1'b0, col_limit_i} > BoundW'(MapColumns)) ?
                   BoundW'(MapColumns) : {1'b0, col_limit_i};
  assign h_bound = ({1'b0, row_limit_i} > BoundW'(MapRows)) ?
                   BoundW'(MapRows) : {1'b0, row_limit_i};

  function automatic logic in_bounds(coord_t x, coord_t y,
                                     logic [BoundW-1:0] wb, logic [BoundW-1:0] hb);
    return !x[CoordW-1] && !y[CoordW-1] &&
           (BoundW'(unsigned'(x)) < wb) && (BoundW'(unsigned'(y)) < hb);
  endfunction

  function automatic logic [AddrW-1:0] pix_addr(coord_t x, coord_t y);
    return AddrW'(y[YIdxW-1:0]) * AddrW'(MapColumns) + AddrW'(x[XIdxW-1:0]);
  endfunction

  function automatic coord_t step(coord_t c, logic neg);
    return neg ? c - CoordW'(1) : c + CoordW'(1);
  endfunction

  brc_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = pix_addr(cx_q, cy_q);
    case (state_q)
      StClear: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_q;
      end
      StIdle: begin
        cmd_pop = !cmd_empty_i && !out_valid_q;
        if (cmd_pop && cmd_i.kind == ReqWrite) begin
          ram_addr  = pix_addr(cmd_i.x, cmd_i.y);
          ram_we    = in_bounds(cmd_i.x, cmd_i.y, w_bound, h_bound);
          ram_wdata = cmd_i.solid;
        end
      end
      default: begin
      end
    endcase
  end

  // Error accumulator and next pixel
  assign err_sum  = err_q + ErrW'(minor_q);
  assign err_wrap = (err_sum >= ErrW'(major_q));
  assign err_next = err_wrap ? err_sum - ErrW'(major_q) : err_sum;

  always_comb begin
    cx_next = cx_q;
    cy_next = cy_q;
    if (x_major_q) begin
      cx_next = step(cx_q, stx_neg_q);
      if (err_wrap) cy_next = step(cy_q, sty_neg_q);
    end else begin
      cy_next = step(cy_q, sty_neg_q);
      if (err_wrap) cx_next = step(cx_q, stx_neg_q);
    end
  end

  assign s1_hit = s1_valid_q && s1_inb_q && ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      walk_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AddrW'(Depth - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (cmd_pop) begin
            if (cmd_i.kind == ReqWrite) begin
              out_valid_q <= 1'b1;
              out_hit_q   <= 1'b0;
              out_data_q  <= '0;
            end else begin
              state_q   <= StCast;
              walk_q    <= 1'b1;
              rem_q     <= cmd_i.major;
              err_q     <= ErrW'(cmd_i.major >> 1);
              cx_q      <= cmd_i.x;
              cy_q      <= cmd_i.y;
              px_q      <= cmd_i.x;
              py_q      <= cmd_i.y;
              x_major_q <= cmd_i.x_major;
              stx_neg_q <= cmd_i.step_x_neg;
              sty_neg_q <= cmd_i.step_y_neg;
              major_q   <= cmd_i.major;
              minor_q   <= cmd_i.minor;
            end
          end
        end
        StCast: begin
          if (s1_hit || (s1_valid_q && s1_last_q)) begin
            // Finish the cast and drop whatever the walker issued behind it
            out_valid_q <= 1'b1;
            out_hit_q   <= s1_hit;
            out_data_q  <= s1_hit ? {s1_y_q, s1_x_q, s1_py_q, s1_px_q} : '0;
            walk_q      <= 1'b0;
            s1_valid_q  <= 1'b0;
            state_q     <= StIdle;
          end else begin
            s1_valid_q <= walk_q;
            if (walk_q) begin
              s1_last_q <= (rem_q == '0);
              s1_inb_q  <= in_bounds(cx_q, cy_q, w_bound, h_bound);
              s1_x_q    <= cx_q;
              s1_y_q    <= cy_q;
              s1_px_q   <= px_q;
              s1_py_q   <= py_q;
              px_q      <= cx_q;
              py_q      <= cy_q;
              cx_q      <= cx_next;
              cy_q      <= cy_next;
              err_q     <= err_next;
              if (rem_q == '0) begin
                walk_q <= 1'b0;
              end else begin
                rem_q <= rem_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign cmd_pop_o    = cmd_pop;
  assign clear_busy_o = (state_q == StClear);
  assign res_valid_o  = out_valid_q;
  assign res_data_o   = out_data_q;
  assign res_user_o   = out_hit_q;

  a_check_only_in_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> state_q == StCast)
    else $error("check stage active outside a cast");

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !out_valid_q && !cmd_pop)
    else $error("activity during the clearing sweep");

  a_pop_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !out_valid_q && !cmd_empty_i)
    else $error("command taken without a free result register");

  a_walk_stops_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q |=> !s1_valid_q)
    else $error("walker issued past the end pixel");

endmodule

// ----- hw/rtl/bresenham_ray_cast_bitmap.sv -----
// Bresenham ray caster over a one-bit solid map of MAP_COLUMNS x MAP_ROWS
// pixels. A request on the input stream either writes one map pixel
// (tuser = 0) or casts a ray from start to end (tuser = 1); every request
// gives exactly one result transaction on the output stream, in order. A cast
// walks the integer Bresenham line, both endpoints included, and stops at the
// first solid pixel inside the configured world; the result then carries
// hit = 1, that pixel and the one visited before it (the start pixel twice
// when the start itself is solid). A miss and a write return hit = 0 with
// all coordinates zero. Pixels at or beyond the configured column count or
// row count (further limited to the map size), or at negative coordinates,
// read as empty, and writes there are dropped. After reset the block sweeps
// the map clear, one pixel per cycle; input stays stalled during the sweep
// while configuration writes are taken as usual. During a cast the single
// map port reads one pixel per cycle, and the read data is registered. A
// short command queue decouples input acceptance from execution, so requests
// are still taken while a result waits on the output, until the queue is
// full. Change the column or row count only while idle.
module bresenham_ray_cast_bitmap #(
  parameter int MAP_COLUMNS = brc_pkg::MapColumnsDef,
  parameter int MAP_ROWS    = brc_pkg::MapRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [brc_pkg::InDataW-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y, solid
  input  logic                         s_axis_tuser,  // req_type
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [brc_pkg::OutDataW-1:0] m_axis_tdata,  // before_x, before_y, impact_x, impact_y
  output logic                         m_axis_tuser,  // hit
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [brc_pkg::CfgW-1:0]     cfg_data_i
);

  import brc_pkg::*;

  logic [CfgW-1:0] col_limit_q, row_limit_q;

  cmd_t front_cmd, queue_cmd;
  logic push, q_full, q_empty, pop, clear_busy;

  // Configuration registers: always ready, one register per transaction
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_limit_q <= WorldWidthRst;
      row_limit_q <= WorldHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegWorldWidth:  col_limit_q <= cfg_data_i;
        RegWorldHeight: row_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify requests
  brc_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .clear_busy_i(clear_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // Queue between front and back
  brc_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CmdQueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (queue_cmd),
    .empty_o(q_empty)
  );

  // Back: clearing sweep, map writes, ray walk and result register
  brc_back #(
    .MapColumns(MAP_COLUMNS),
    .MapRows   (MAP_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_limit_i (col_limit_q),
    .row_limit_i (row_limit_q),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (pop),
    .clear_busy_o(clear_busy),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_user_o  (m_axis_tuser)
  );

endmodule
